// ----- design/utrr_pkg.sv -----
`default_nettype none

package utrr_pkg;

  typedef enum logic [1:0] {
    CMD_PUT_TX   = 2'd0,
    CMD_TAKE_RX  = 2'd1,
    CMD_LINE_RX  = 2'd2,
    CMD_TX_EMPTY = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] data_out;
    logic       line_send;
    logic       tx_irq_enabled;
    logic       driver_enable;
    logic       rx_not_empty;
    logic       tx_has_space;
  } out_item_t;

  // ring status as seen before the current request
  typedef struct packed {
    logic can_push;
    logic can_pop;
  } ring_stat_t;

endpackage

`default_nettype wire

// ----- design/utrr_ram.sv -----
`default_nettype none

module utrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/utrr_ring.sv -----
`default_nettype none

module utrr_ring
  import utrr_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [7:0] wdata,
  input  wire logic       pop,
  output ring_stat_t      stat,
  output logic [7:0]      rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W-1:0] wptr_inc, rptr_inc;
  logic             push_ok, pop_ok;

  // wrap-around increment, one slot kept free
  assign wptr_inc = (wptr_r == LAST) ? '0 : wptr_r + 1'b1;
  assign rptr_inc = (rptr_r == LAST) ? '0 : rptr_r + 1'b1;

  assign stat.can_push = (wptr_inc != rptr_r);
  assign stat.can_pop  = (wptr_r != rptr_r);

  assign push_ok = push & stat.can_push;
  assign pop_ok  = pop & stat.can_pop;

  always_comb begin
    wptr_nxt = push_ok ? wptr_inc : wptr_r;
    rptr_nxt = pop_ok  ? rptr_inc : rptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  utrr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (wptr_r),
    .wdata (wdata),
    .raddr (rptr_r),
    .rdata (rdata)
  );

`ifndef SYNTH
  // a full ring is never empty
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.can_push |-> stat.can_pop)
    else $error("ring full and empty at once");

  // a refused push leaves the write pointer alone
  a_push_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !stat.can_push) |=> $stable(wptr_r))
    else $error("write pointer moved on full ring");
`endif

endmodule

`default_nettype wire

// ----- design/uart_tx_rx_ring_buffers.sv -----
// channel   | handshake        | payload                  | direction
// ----------+------------------+--------------------------+----------
// request   | start / busy     | in_data  (in_item_t)     | in
// result    | out_valid strobe | out_data (out_item_t)    | out
// config    | cfg_we           | cfg_wdata (rs485_mode)   | in
//
// busy stays low: a request is taken in every cycle that start is high
// each result appears for exactly one cycle, the cycle after its request
// results are registered; read data comes from the registered read of the ring memories
// synchronous active-low reset clears pointers, interrupt enable, driver
// enable and rs485 mode; ring memory contents are not cleared
// the receiver cannot stall, so nothing ever waits on the result side

`default_nettype none

module uart_tx_rx_ring_buffers
  import utrr_pkg::*;
#(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_data,
  output logic          out_valid,
  output out_item_t     out_data,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata
);

  logic       accept;
  logic       is_put, is_take, is_line, is_tx_empty;
  ring_stat_t tx_stat, rx_stat;
  logic [7:0] tx_q, rx_q;

  logic rs485_mode_r;
  logic tx_irq_on_r, tx_irq_on_nxt;
  logic driver_on_r, driver_on_nxt;

  // result stage
  logic out_valid_r, out_valid_nxt;
  logic accepted_r, accepted_nxt;
  logic take_ok_r, take_ok_nxt;
  logic send_ok_r, send_ok_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // decode the request
  assign is_put      = accept && (in_data.cmd == CMD_PUT_TX);
  assign is_take     = accept && (in_data.cmd == CMD_TAKE_RX);
  assign is_line     = accept && (in_data.cmd == CMD_LINE_RX);
  assign is_tx_empty = accept && (in_data.cmd == CMD_TX_EMPTY);

  // transmit ring: filled by software, drained by the transmitter
  utrr_ring #(
    .DEPTH (TX_DEPTH)
  ) u_tx_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (is_put),
    .wdata (in_data.data_in),
    .pop   (is_tx_empty),
    .stat  (tx_stat),
    .rdata (tx_q)
  );

  // receive ring: filled by the line, drained by software
  utrr_ring #(
    .DEPTH (RX_DEPTH)
  ) u_rx_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (is_line),
    .wdata (in_data.data_in),
    .pop   (is_take),
    .stat  (rx_stat),
    .rdata (rx_q)
  );

  always_comb begin
    tx_irq_on_nxt = tx_irq_on_r;
    driver_on_nxt = driver_on_r;
    out_valid_nxt = accept;
    take_ok_nxt   = is_take & rx_stat.can_pop;
    send_ok_nxt   = is_tx_empty & tx_stat.can_pop;
    accepted_nxt  = 1'b0;
    case (in_data.cmd)
      CMD_PUT_TX: begin
        accepted_nxt = tx_stat.can_push;
        // queueing a byte arms the transmit-empty interrupt
        if (is_put && tx_stat.can_push) begin
          tx_irq_on_nxt = 1'b1;
        end
      end
      CMD_TAKE_RX: begin
        accepted_nxt = rx_stat.can_pop;
      end
      CMD_LINE_RX: begin
        // byte dropped when the receive ring is full
        accepted_nxt = rx_stat.can_push;
      end
      CMD_TX_EMPTY: begin
        accepted_nxt = tx_stat.can_pop;
        if (is_tx_empty) begin
          if (!tx_stat.can_pop) begin
            // nothing left to send: disarm the interrupt
            tx_irq_on_nxt = 1'b0;
          end else if (rs485_mode_r) begin
            // driver enable is only ever raised here; only reset drops it
            driver_on_nxt = 1'b1;
          end
        end
      end
      default: begin
        accepted_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs485_mode_r <= 1'b0;
      tx_irq_on_r  <= 1'b0;
      driver_on_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      accepted_r   <= 1'b0;
      take_ok_r    <= 1'b0;
      send_ok_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        rs485_mode_r <= cfg_wdata;
      end
      tx_irq_on_r <= tx_irq_on_nxt;
      driver_on_r <= driver_on_nxt;
      out_valid_r <= out_valid_nxt;
      accepted_r  <= accepted_nxt;
      take_ok_r   <= take_ok_nxt;
      send_ok_r   <= send_ok_nxt;
    end
  end

  // the ring pointers and flags already hold the state after the request,
  // so the status fields come straight from them in the result cycle
  assign out_valid               = out_valid_r;
  assign out_data.accepted       = accepted_r;
  assign out_data.data_out       = take_ok_r ? rx_q : (send_ok_r ? tx_q : 8'd0);
  assign out_data.line_send      = send_ok_r;
  assign out_data.tx_irq_enabled = tx_irq_on_r;
  assign out_data.driver_enable  = driver_on_r;
  assign out_data.rx_not_empty   = rx_stat.can_pop;
  assign out_data.tx_has_space   = tx_stat.can_push;

`ifndef SYNTH
  // every request gives exactly one result in the following cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without request");

  // once raised the driver enable stays high
  a_driver_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    driver_on_r |=> driver_on_r)
    else $error("driver enable dropped");

  // a byte is sent only when the transmit ring was non-empty
  a_send_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.line_send) |-> out_data.accepted)
    else $error("line send without a queued byte");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_uart_tx_rx_ring_buffers.sv -----
`timescale 1ns / 100ps

module tb_uart_tx_rx_ring_buffers;
  import utrr_pkg::*;

  localparam int TX_DEPTH     = 64;
  localparam int RX_DEPTH     = 64;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  // settle time after the last result, before touching the register
  localparam int SETTLE_CYCLES = 4;
  // ~900 requests, worst phase idles at 82 percent: far below this
  localparam int LIMIT_CYCLES  = 200000;
  localparam int RANDOM_PER_PHASE = 225;
  localparam int NUM_PHASES    = 4;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  uart_tx_rx_ring_buffers #(
    .TX_DEPTH(TX_DEPTH),
    .RX_DEPTH(RX_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // requests waiting to be driven, and the status words they should produce
  in_item_t  pending_req_q[$];
  out_item_t expected_status_q[$];

  // sender idle chance per cycle, in percent, set per phase
  int unsigned idle_pct = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------
  // shadow of the block: both rings, interrupt enable, driver line
  // ---------------------------------------------------------------
  logic [7:0] tx_ring_mem [TX_DEPTH];
  logic [7:0] rx_ring_mem [RX_DEPTH];
  int         tx_head = 0;   // next slot to write
  int         tx_tail = 0;   // next slot to send
  int         rx_head = 0;
  int         rx_tail = 0;
  logic       tx_irq_shadow = 1'b0;
  logic       drv_en_shadow = 1'b0;
  logic       rs485_shadow  = 1'b0;

  function automatic int next_slot(int p, int depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  // applies one request to the shadow rings and returns the status word
  function automatic out_item_t predict_ring_status(in_item_t req);
    out_item_t st;
    int        nxt;
    st = '0;
    case (req.cmd)
      CMD_PUT_TX: begin
        // one slot always left empty, so full is head+1 == tail
        nxt = next_slot(tx_head, TX_DEPTH);
        if (nxt != tx_tail) begin
          tx_ring_mem[tx_head] = req.data_in;
          tx_head       = nxt;
          tx_irq_shadow = 1'b1;
          st.accepted   = 1'b1;
        end
      end
      CMD_TAKE_RX: begin
        // empty receive ring refuses, tail stays put
        if (rx_tail != rx_head) begin
          st.data_out = rx_ring_mem[rx_tail];
          rx_tail     = next_slot(rx_tail, RX_DEPTH);
          st.accepted = 1'b1;
        end
      end
      CMD_LINE_RX: begin
        // byte dropped when the receive ring is full
        nxt = next_slot(rx_head, RX_DEPTH);
        if (nxt != rx_tail) begin
          rx_ring_mem[rx_head] = req.data_in;
          rx_head     = nxt;
          st.accepted = 1'b1;
        end
      end
      CMD_TX_EMPTY: begin
        if (tx_head == tx_tail) begin
          // nothing queued: interrupt enable cleared, set or not
          tx_irq_shadow = 1'b0;
        end else begin
          // driver line is sticky, never lowered here
          if (rs485_shadow) drv_en_shadow = 1'b1;
          st.data_out  = tx_ring_mem[tx_tail];
          tx_tail      = next_slot(tx_tail, TX_DEPTH);
          st.line_send = 1'b1;
          st.accepted  = 1'b1;
        end
      end
      default: ;
    endcase
    st.tx_irq_enabled = tx_irq_shadow;
    st.driver_enable  = drv_en_shadow;
    st.rx_not_empty   = (rx_tail != rx_head);
    st.tx_has_space   = (next_slot(tx_head, TX_DEPTH) != tx_tail);
    return st;
  endfunction

  // ---------------------------------------------------------------
  // driver: presents queued requests, idling at random per phase
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // register write lands at this edge, before any later request
      if (cfg_we) rs485_shadow = cfg_wdata;
      // request taken at this edge: work out its status word
      if (start && !busy) expected_status_q.push_back(predict_ring_status(in_data));
      if (!start || !busy) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start   <= 1'b1;
          in_data <= pending_req_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: every strobed status word against the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_status_q.size() == 0) begin
        $error("status word with no request outstanding: %h", out_data);
        fail_count++;
      end else begin
        want = expected_status_q.pop_front();
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
          fail_count++;
        end
        if (out_data.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, out_data.data_out);
          fail_count++;
        end
        if (out_data.line_send !== want.line_send) begin
          $error("line_send: expected %0d, got %0d", want.line_send, out_data.line_send);
          fail_count++;
        end
        if (out_data.tx_irq_enabled !== want.tx_irq_enabled) begin
          $error("tx_irq_enabled: expected %0d, got %0d",
                 want.tx_irq_enabled, out_data.tx_irq_enabled);
          fail_count++;
        end
        if (out_data.driver_enable !== want.driver_enable) begin
          $error("driver_enable: expected %0d, got %0d",
                 want.driver_enable, out_data.driver_enable);
          fail_count++;
        end
        if (out_data.rx_not_empty !== want.rx_not_empty) begin
          $error("rx_not_empty: expected %0d, got %0d",
                 want.rx_not_empty, out_data.rx_not_empty);
          fail_count++;
        end
        if (out_data.tx_has_space !== want.tx_has_space) begin
          $error("tx_has_space: expected %0d, got %0d",
                 want.tx_has_space, out_data.tx_has_space);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  function automatic void queue_request(cmd_t c, logic [7:0] d);
    in_item_t req;
    req.cmd     = c;
    req.data_in = d;
    pending_req_q.push_back(req);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // bursts long enough to fill or empty a ring, so full and empty
  // cases come up often; short mixed bursts as noise in between
  function automatic void queue_random_traffic(int count);
    int n;
    int kind;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(5);
      case (kind)
        0: repeat ($urandom_range(1, 70)) begin
             queue_request(CMD_PUT_TX, rand_byte()); n++;
           end
        1: repeat ($urandom_range(1, 70)) begin
             queue_request(CMD_TX_EMPTY, rand_byte()); n++;
           end
        2: repeat ($urandom_range(1, 70)) begin
             queue_request(CMD_LINE_RX, rand_byte()); n++;
           end
        3: repeat ($urandom_range(1, 70)) begin
             queue_request(CMD_TAKE_RX, rand_byte()); n++;
           end
        4: repeat ($urandom_range(1, 20)) begin
             queue_request(cmd_t'($urandom_range(3)), rand_byte()); n++;
           end
        default: repeat ($urandom_range(1, 20)) begin
             // echo-style traffic: queue and send back to back
             queue_request(CMD_PUT_TX, rand_byte());
             queue_request(CMD_TX_EMPTY, rand_byte());
             n += 2;
           end
      endcase
    end
  endfunction

  // block idle: nothing queued, nothing in flight, latency run out
  task automatic wait_for_idle();
    while (pending_req_q.size() != 0 || start || expected_status_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rs485_mode(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    // phase settings: sender idling and rs485 mode; clearing the mode
    // after the line was raised checks that the driver line stays high
    int unsigned phase_idle [NUM_PHASES] = '{0, 82, 0, 36};
    logic        phase_mode [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_idle();
      write_rs485_mode(phase_mode[ph]);
      idle_pct = phase_idle[ph];

      if (ph == 0) begin
        // transmit path with extreme bytes, then sends
        queue_request(CMD_PUT_TX, 8'h00);
        queue_request(CMD_PUT_TX, 8'hFF);
        queue_request(CMD_TX_EMPTY, 8'h00);
        queue_request(CMD_TX_EMPTY, 8'hFF);
        // register empty on empty ring, enable set then already clear
        queue_request(CMD_TX_EMPTY, 8'h5A);
        queue_request(CMD_TX_EMPTY, 8'hA5);
        // take from empty receive ring
        queue_request(CMD_TAKE_RX, 8'hFF);
        // receive path with extreme bytes
        queue_request(CMD_LINE_RX, 8'hFF);
        queue_request(CMD_LINE_RX, 8'h00);
        queue_request(CMD_TAKE_RX, 8'h00);
        queue_request(CMD_TAKE_RX, 8'hFF);
        queue_request(CMD_TAKE_RX, 8'h00);
        // interleaved traffic on both rings
        queue_request(CMD_LINE_RX, 8'hA5);
        queue_request(CMD_PUT_TX, 8'h5A);
        queue_request(CMD_TAKE_RX, 8'h3C);
        queue_request(CMD_TX_EMPTY, 8'hC3);
        queue_request(CMD_TX_EMPTY, 8'h00);
      end

      queue_random_traffic(RANDOM_PER_PHASE);
    end

    wait_for_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/utrr_pkg.sv
design/utrr_ram.sv
design/utrr_ring.sv
design/uart_tx_rx_ring_buffers.sv
tb/tb_uart_tx_rx_ring_buffers.sv
